// ===== hdl/min_heap_insert_delete_min_unit_macros.svh =====
// Assertion macros shared by the heap unit's checker.
// Depends on nothing; take in by `include.
`ifndef MIN_HEAP_INSERT_DELETE_MIN_UNIT_MACROS_SVH
`define MIN_HEAP_INSERT_DELETE_MIN_UNIT_MACROS_SVH

// Overlapping implication, disabled during reset.
`define MH_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mhidm_pkg.sv =====
// Package for the min-heap unit: request/result structs, codes, defaults.
// No dependencies.
package mhidm_pkg;

  localparam int HEAP_CAPACITY = 1024;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;
  // Spare code, served as a query.
  localparam logic [1:0] FUNC_SPARE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] min_value;
    logic [1:0]         status;
    logic [10:0]        entry_count;
  } rsp_t;

endpackage

// ===== hdl/min_heap_insert_delete_min_unit.sv =====
// Min-heap unit: insert, delete by value, query minimum over one RAM.
// Depends on mhidm_pkg.
//
// One request at a time. A query goes straight to the result step. An
// insert rises one read-compare pair per parent (S_UP_RD, S_UP_CMP), then
// ends with a final write and the result. A delete scans the store one
// entry per cycle from index 0; an absent value, or an empty heap, ends the
// scan as not found. After a match, the last entry is fetched (S_LAST,
// S_LWAIT), then rises by read-compare pairs and sinks by a left read, a
// right read and a compare per level (S_DN_L, S_DN_R, S_DN_CMP), before a
// final write and the result; a match at the last entry goes straight to
// the result. All steps share the single-port read / single-port write heap
// RAM; in_stall is high from acceptance until the result is registered, and
// longer while a waiting result is stalled. The result register lets a new
// request enter while the previous result waits.
module min_heap_insert_delete_min_unit #(
  parameter int CAPACITY = mhidm_pkg::HEAP_CAPACITY
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mhidm_pkg::req_t   in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mhidm_pkg::rsp_t   out_data
);
  import mhidm_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_UP_RD  = 4'd1;
  localparam logic [3:0] S_UP_CMP = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_LAST   = 4'd4;
  localparam logic [3:0] S_LWAIT  = 4'd5;
  localparam logic [3:0] S_DN_L   = 4'd6;
  localparam logic [3:0] S_DN_R   = 4'd7;
  localparam logic [3:0] S_DN_CMP = 4'd8;
  localparam logic [3:0] S_FINAL  = 4'd9;
  localparam logic [3:0] S_RESP   = 4'd10;

  logic signed [31:0] mem [CAPACITY];
  logic signed [31:0] mem_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic               wr_en;
  logic signed [31:0] wr_data;

  logic [3:0]         state, state_next;
  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      pos, pos_next;
  logic signed [31:0] cur_val, cur_val_next;
  logic signed [31:0] key, key_next;
  logic signed [31:0] lval, lval_next;
  logic signed [31:0] root;
  logic               do_down, do_down_next;
  logic               have_r, have_r_next;
  logic [CW-1:0]      scan_idx, scan_idx_next;
  logic [AW-1:0]      q_idx, q_idx_next;
  logic               q_pend, q_pend_next;
  logic [1:0]         status, status_next;

  logic [AW-1:0]      parent;
  logic [AW:0]        lc, rc, cnt_w;
  logic               load_out;

  assign parent = (pos - AW'(1)) >> 1;
  assign lc     = {pos, 1'b1};
  assign rc     = {pos, 1'b0} + (AW+1)'(2);
  assign cnt_w  = (AW+1)'(count);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_comb begin
    state_next    = state;
    count_next    = count;
    pos_next      = pos;
    cur_val_next  = cur_val;
    key_next      = key;
    lval_next     = lval;
    do_down_next  = do_down;
    have_r_next   = have_r;
    scan_idx_next = scan_idx;
    q_idx_next    = q_idx;
    q_pend_next   = q_pend;
    status_next   = status;
    rd_addr       = pos;
    wr_addr       = pos;
    wr_en         = 1'b0;
    wr_data       = cur_val;
    load_out      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          key_next    = in_data.value;
          status_next = ST_OK;
          case (in_data.func)
            FUNC_INSERT: begin
              if (count >= CW'(CAPACITY)) begin
                status_next = ST_FULL;
                state_next  = S_RESP;
              end else begin
                pos_next     = count[AW-1:0];
                count_next   = count + CW'(1);
                cur_val_next = in_data.value;
                do_down_next = 1'b0;
                state_next   = S_UP_RD;
              end
            end
            FUNC_DELETE: begin
              scan_idx_next = '0;
              q_pend_next   = 1'b0;
              state_next    = S_SCAN;
            end
            default: begin
              if (count == '0) status_next = ST_EMPTY;
              state_next = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        // Compare the entry read last cycle while the next read issues.
        if (q_pend && mem_q == key) begin
          pos_next   = q_idx;
          count_next = count - CW'(1);
          state_next = S_LAST;
        end else if (scan_idx < count) begin
          rd_addr       = scan_idx[AW-1:0];
          q_pend_next   = 1'b1;
          q_idx_next    = scan_idx[AW-1:0];
          scan_idx_next = scan_idx + CW'(1);
        end else if (q_pend) begin
          q_pend_next = 1'b0;
        end else begin
          status_next = ST_NOT_FOUND;
          state_next  = S_RESP;
        end
      end
      S_LAST: begin
        rd_addr = count[AW-1:0];
        if (CW'(pos) == count) state_next = S_RESP;
        else                   state_next = S_LWAIT;
      end
      S_LWAIT: begin
        cur_val_next = mem_q;
        do_down_next = 1'b1;
        state_next   = S_UP_RD;
      end
      S_UP_RD: begin
        rd_addr = parent;
        if (pos == '0) state_next = do_down ? S_DN_L : S_FINAL;
        else           state_next = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (mem_q > cur_val) begin
          // Move the parent down into the hole.
          wr_en      = 1'b1;
          wr_data    = mem_q;
          pos_next   = parent;
          state_next = S_UP_RD;
        end else begin
          state_next = do_down ? S_DN_L : S_FINAL;
        end
      end
      S_DN_L: begin
        rd_addr = lc[AW-1:0];
        if (lc >= cnt_w) state_next = S_FINAL;
        else             state_next = S_DN_R;
      end
      S_DN_R: begin
        lval_next   = mem_q;
        rd_addr     = rc[AW-1:0];
        have_r_next = (rc < cnt_w);
        state_next  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (have_r && mem_q < lval) begin
          if (cur_val > mem_q) begin
            wr_en      = 1'b1;
            wr_data    = mem_q;
            pos_next   = rc[AW-1:0];
            state_next = S_DN_L;
          end else begin
            state_next = S_FINAL;
          end
        end else if (cur_val > lval) begin
          wr_en      = 1'b1;
          wr_data    = lval;
          pos_next   = lc[AW-1:0];
          state_next = S_DN_L;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_FINAL: begin
        wr_en      = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        // Hold until the result register is free.
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      q_pend    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      q_pend <= q_pend_next;
      if (load_out)       out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pos      <= pos_next;
    cur_val  <= cur_val_next;
    key      <= key_next;
    lval     <= lval_next;
    do_down  <= do_down_next;
    have_r   <= have_r_next;
    scan_idx <= scan_idx_next;
    q_idx    <= q_idx_next;
    status   <= status_next;
    if (wr_en && wr_addr == '0) root <= wr_data;
    if (load_out) begin
      out_data.min_value   <= (count == '0) ? 32'sd0 : root;
      out_data.status      <= status;
      out_data.entry_count <= 11'(count);
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

// ===== hdl/mhidm_checker.sv =====
// Port-level checker for the min-heap unit, bound to the unit module.
// Depends on mhidm_pkg and min_heap_insert_delete_min_unit_macros.svh.
`include "min_heap_insert_delete_min_unit_macros.svh"

module mhidm_checker #(
  parameter int CAPACITY = mhidm_pkg::HEAP_CAPACITY
) (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input mhidm_pkg::rsp_t out_data,
  input logic            out_valid,
  input logic            out_stall
);
  import mhidm_pkg::*;

  `MH_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_data), "result changed while stalled")
  `MH_ASSERT_IMPL(a_empty_min, out_valid && out_data.entry_count == 11'd0,
    out_data.min_value == 32'sd0, "empty heap with nonzero minimum")
  `MH_ASSERT_IMPL(a_empty_code, out_valid && out_data.status == ST_EMPTY,
    out_data.entry_count == 11'd0, "empty status with entries stored")
  `MH_ASSERT_IMPL(a_full_code, out_valid && out_data.status == ST_FULL,
    out_data.entry_count == 11'(CAPACITY), "full status below capacity")
  `MH_ASSERT_NEXT(a_in_busy, in_valid && !in_stall, in_stall,
    "input not stalled after a transaction")

endmodule

bind min_heap_insert_delete_min_unit mhidm_checker #(.CAPACITY(CAPACITY)) u_mhidm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_data(out_data), .out_valid(out_valid), .out_stall(out_stall)
);
